/* rtl/vq_tile_skip_mask_decoder_assert.svh */
// Assertion macros for the port-level checker of the tile skip-mask decoder.
`ifndef VQ_TILE_SKIP_MASK_DECODER_ASSERT_SVH
`define VQ_TILE_SKIP_MASK_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define VTSM_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vtsm check failed");

// Next-cycle implication, disabled while reset is asserted
`define VTSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vtsm check failed");

`endif

/* rtl/vtsm_pkg.sv */
// Types and constants shared by the tile skip-mask decoder modules.
package vtsm_pkg;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgTilesAcross    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTilesDown      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCodebookEntries = 2'd2;

  localparam logic [6:0]  ResetTilesAcross    = 7'd40;
  localparam logic [5:0]  ResetTilesDown      = 6'd25;
  localparam logic [15:0] ResetCodebookEntries = 16'd256;

  // Result status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StBadIndex  = 2'd1;
  localparam logic [1:0] StNoHistory = 2'd2;
  localparam logic [1:0] StTruncated = 2'd3;

  // Results per input byte, and the emission counter that tracks them
  localparam int MaxResults = 32;
  localparam int CntW       = $clog2(MaxResults);
  localparam logic [CntW-1:0] CntLast = CntW'(MaxResults - 1);

  // Good frames needed before a history copy is legal
  localparam logic [1:0] FramesForHistory = 2'd2;

  // Bytes in a column's skip mask, counted from zero
  localparam logic [1:0] MaskLastByte = 2'd3;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       first_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]  tile_column;
    logic [4:0]  tile_row;
    logic        from_history;
    logic [15:0] codebook_index;
    logic [1:0]  status;
    logic        frame_complete;
    logic        run_last;
  } out_beat_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic work;
    logic out_free;
  } sts_t;

endpackage

/* rtl/vtsm_ctrl.sv */
// Controller: sequences byte intake and one result per cycle when output is free.
module vtsm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  vtsm_pkg::sts_t sts_i,
  output vtsm_pkg::cmd_t cmd_o,
  output logic           in_ready_o
);

  typedef enum logic {
    StIdle,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  // Commands
  always_comb begin
    cmd_o.accept = in_valid_i && in_ready_q;
    cmd_o.emit   = (state_q == StEmit) && sts_i.out_free;
  end

  // Next state: stay in emit until the last result of the byte is loaded
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_o.accept && sts_i.work) state_d = StEmit;
      end
      StEmit: begin
        if (cmd_o.emit && !sts_i.work) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == StIdle);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

/* rtl/vtsm_datapath.sv */
// Datapath: config registers, mask and index assembly, tile walk, output register.
module vtsm_datapath #(
  parameter int MAX_TILES_X = 64,
  parameter int MAX_TILES_Y = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vtsm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vtsm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  vtsm_pkg::in_beat_t             in_data_i,
  input  logic                           out_ready_i,
  input  vtsm_pkg::cmd_t                 cmd_i,
  output vtsm_pkg::sts_t                 sts_o,
  output logic                           out_valid_o,
  output vtsm_pkg::out_beat_t            out_data_o
);

  localparam int CW = (MAX_TILES_X > 1) ? $clog2(MAX_TILES_X) : 1;
  localparam int RW = (MAX_TILES_Y > 1) ? $clog2(MAX_TILES_Y) : 1;

  typedef enum logic [1:0] {
    PhIdle,
    PhMask,
    PhIndex
  } phase_e;

  // Configuration
  logic [6:0]  across_q;
  logic [5:0]  down_q;
  logic [15:0] entries_q;

  // Walk state
  phase_e                    phase_q, phase_d;
  logic [31:0]               mask_q, mask_d;
  logic [1:0]                bc_q, bc_d;
  logic [7:0]                hi_q, hi_d;
  logic [CW-1:0]             col_q, col_d;
  logic [RW-1:0]             row_q, row_d;
  logic [1:0]                frames_q, frames_d;
  logic                      pend_q, pend_d;
  logic                      last_q, last_d;
  logic [vtsm_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [15:0]               idx_q, idx_d;

  // Start-of-byte view (a first byte opens a fresh frame)
  phase_e        st_phase;
  logic [31:0]   st_mask;
  logic [1:0]    st_bc;
  logic [7:0]    st_hi;
  logic [CW-1:0] st_col;
  logic [RW-1:0] st_row;

  // Emission helpers
  logic [CW:0] eff_cols, col_inc;
  logic [RW:0] eff_rows, row_inc;
  logic        cand_idx, cand_skip, idx_bad, no_hist, adv;
  logic        row_wrap, col_done, finish, fold, work;

  vtsm_pkg::out_beat_t res;
  vtsm_pkg::out_beat_t out_data_q;
  logic                out_valid_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q  <= vtsm_pkg::ResetTilesAcross;
      down_q    <= vtsm_pkg::ResetTilesDown;
      entries_q <= vtsm_pkg::ResetCodebookEntries;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vtsm_pkg::CfgTilesAcross:     across_q  <= cfg_wdata_i[6:0];
        vtsm_pkg::CfgTilesDown:       down_q    <= cfg_wdata_i[5:0];
        vtsm_pkg::CfgCodebookEntries: entries_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamped frame size
  always_comb begin
    if (across_q == '0) eff_cols = (CW+1)'(1);
    else if (int'(across_q) > MAX_TILES_X) eff_cols = (CW+1)'(MAX_TILES_X);
    else eff_cols = (CW+1)'(across_q);
    if (down_q == '0) eff_rows = (RW+1)'(1);
    else if (int'(down_q) > MAX_TILES_Y) eff_rows = (RW+1)'(MAX_TILES_Y);
    else eff_rows = (RW+1)'(down_q);
  end

  always_comb begin
    st_phase = in_data_i.first_byte ? PhMask : phase_q;
    st_mask  = in_data_i.first_byte ? '0 : mask_q;
    st_bc    = in_data_i.first_byte ? '0 : bc_q;
    st_hi    = in_data_i.first_byte ? '0 : hi_q;
    st_col   = in_data_i.first_byte ? '0 : col_q;
    st_row   = in_data_i.first_byte ? '0 : row_q;
  end

  // What the next result is, and the tile step it takes
  always_comb begin
    cand_idx  = pend_q;
    cand_skip = !pend_q && (phase_q == PhIndex) && mask_q[31];
    idx_bad   = idx_q >= entries_q;
    no_hist   = frames_q < vtsm_pkg::FramesForHistory;
    adv       = (cand_idx && !idx_bad) || (cand_skip && !no_hist);
    row_inc   = (RW+1)'(row_q) + (RW+1)'(1);
    col_inc   = (CW+1)'(col_q) + (CW+1)'(1);
    row_wrap  = row_inc >= eff_rows;
    col_done  = col_inc >= eff_cols;
    finish    = adv && row_wrap && col_done;
  end

  // Next state for a byte intake or for one emission
  always_comb begin
    phase_d  = phase_q;
    mask_d   = mask_q;
    bc_d     = bc_q;
    hi_d     = hi_q;
    col_d    = col_q;
    row_d    = row_q;
    frames_d = frames_q;
    pend_d   = pend_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    fold     = 1'b0;

    if (cmd_i.accept) begin
      phase_d = st_phase;
      mask_d  = st_mask;
      bc_d    = st_bc;
      hi_d    = st_hi;
      col_d   = st_col;
      row_d   = st_row;
      pend_d  = 1'b0;
      last_d  = in_data_i.last_byte;
      cnt_d   = '0;
      unique case (st_phase)
        PhMask: begin
          mask_d = {st_mask[23:0], in_data_i.body_byte};
          if (st_bc == vtsm_pkg::MaskLastByte) begin
            bc_d    = '0;
            phase_d = PhIndex;
          end else begin
            bc_d = st_bc + 2'd1;
          end
        end
        PhIndex: begin
          if (st_bc == '0) begin
            hi_d = in_data_i.body_byte;
            bc_d = 2'd1;
          end else begin
            // Low index byte: the index uses up one mask bit
            idx_d  = {st_hi, in_data_i.body_byte};
            bc_d   = '0;
            mask_d = {st_mask[30:0], 1'b0};
            pend_d = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.emit) begin
      pend_d = 1'b0;
      cnt_d  = cnt_q + vtsm_pkg::CntW'(1);
      if (cand_skip && !no_hist) mask_d = {mask_q[30:0], 1'b0};
      if (adv) begin
        row_d = row_wrap ? '0 : row_inc[RW-1:0];
        if (row_wrap) begin
          if (col_done) begin
            phase_d = PhIdle;
            if (frames_q != vtsm_pkg::FramesForHistory) frames_d = frames_q + 2'd1;
          end else begin
            col_d   = col_inc[CW-1:0];
            phase_d = PhMask;
            bc_d    = '0;
            mask_d  = '0;
          end
        end
      end else begin
        // Bad index, missing history or truncation closes the frame
        phase_d = PhIdle;
      end
      // Result budget used up: truncation marks the last result instead
      if ((cnt_q == vtsm_pkg::CntLast) && last_q && (phase_d != PhIdle)) begin
        fold    = 1'b1;
        phase_d = PhIdle;
      end
    end

    work = pend_d || ((phase_d == PhIndex) && mask_d[31]) || (last_d && (phase_d != PhIdle));
  end

  // Result of this emission
  always_comb begin
    res.tile_column    = 6'(col_q);
    res.tile_row       = 5'(row_q);
    res.from_history   = cand_skip;
    res.codebook_index = cand_idx ? idx_q : '0;
    if (cand_idx) res.status = idx_bad ? vtsm_pkg::StBadIndex : vtsm_pkg::StOk;
    else if (cand_skip) res.status = no_hist ? vtsm_pkg::StNoHistory : vtsm_pkg::StOk;
    else res.status = vtsm_pkg::StTruncated;
    if (fold) res.status = vtsm_pkg::StTruncated;
    res.frame_complete = finish;
    res.run_last       = !work;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      mask_q   <= '0;
      bc_q     <= '0;
      hi_q     <= '0;
      col_q    <= '0;
      row_q    <= '0;
      frames_q <= '0;
      pend_q   <= 1'b0;
      last_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      mask_q   <= mask_d;
      bc_q     <= bc_d;
      hi_q     <= hi_d;
      col_q    <= col_d;
      row_q    <= row_d;
      frames_q <= frames_d;
      pend_q   <= pend_d;
      last_q   <= last_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_data_q <= res;
  end

  assign sts_o.work     = work;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule

/* rtl/vq_tile_skip_mask_decoder.sv */
// Top level of the tile skip-mask decoder.
//
// Input channel: one body byte per beat, with first_byte opening a frame
// body and last_byte closing it. Output channel: one tile command per beat.
// Configuration: write tiles_across, tiles_down and codebook_entries through
// cfg_we_i / cfg_index_i / cfg_wdata_i while the block is idle.
//
// A byte that causes k results has them emitted one result per cycle while
// the output register is free, as the controller walks the mask bits
// through the shared tile-step logic. The first result is loaded into the
// output register by the first emission of the byte. Up to 32 results follow
// one byte (a run of skipped tiles); run_last marks the final one.
// in_ready_o stays low while the results of a byte are being produced.
// A stalled receiver holds the output register and pauses emission; the
// next byte is still taken once all results of the previous byte are queued.
// Reset clears the walk (no open frame, no decoded frames) and loads the
// configuration defaults of 40 columns, 25 rows and 256 codebook entries.
module vq_tile_skip_mask_decoder #(
  parameter int MAX_TILES_X = 64,
  parameter int MAX_TILES_Y = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vtsm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vtsm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  vtsm_pkg::in_beat_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output vtsm_pkg::out_beat_t           out_data_o
);

  vtsm_pkg::cmd_t cmd;
  vtsm_pkg::sts_t sts;

  vtsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  vtsm_datapath #(
    .MAX_TILES_X (MAX_TILES_X),
    .MAX_TILES_Y (MAX_TILES_Y)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/vtsm_checker.sv */
// Port-level checks on the tile skip-mask decoder, bound to its top level.
`include "vq_tile_skip_mask_decoder_assert.svh"

module vtsm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input vtsm_pkg::out_beat_t out_data_o
);

  // A stalled result beat stays put
  `VTSM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // A finished frame is a good tile and ends the byte's run
  `VTSM_ASSERT(a_complete_ok, clk_i, rst_ni, out_valid_o && out_data_o.frame_complete, out_data_o.run_last && (out_data_o.status == vtsm_pkg::StOk))

  // History tiles never carry a codebook index
  `VTSM_ASSERT(a_hist_no_index, clk_i, rst_ni, out_valid_o && out_data_o.from_history, out_data_o.codebook_index == 16'd0)

  // A missing history frame comes from a skip and closes the run
  `VTSM_ASSERT(a_no_hist_last, clk_i, rst_ni, out_valid_o && (out_data_o.status == vtsm_pkg::StNoHistory), out_data_o.from_history && out_data_o.run_last)

endmodule

bind vq_tile_skip_mask_decoder vtsm_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* bench/tile_command_checker.sv */
`timescale 1ns / 100ps
// Watches the decoder channels, predicts every tile command and compares it.
module tile_command_checker
  import vtsm_pkg::*;
#(
  parameter int MAX_TILES_X = 64,
  parameter int MAX_TILES_Y = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_beat_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_beat_t           out_data_i,
  output int unsigned         tiles_pending_o,
  output int unsigned         mismatch_count_o
);

  localparam int MaskBytes  = 4;
  localparam int MaxReports = 10;

  typedef enum logic [1:0] {
    PhIdle,
    PhMask,
    PhIndex
  } walk_phase_e;

  // Register copies
  logic [6:0]  cfg_across;
  logic [5:0]  cfg_down;
  logic [15:0] cfg_entries;

  // Frame walk state
  walk_phase_e walk_phase;
  logic [31:0] mask_bits;
  int unsigned mask_count;
  logic [7:0]  index_hi;
  int unsigned col_at;
  int unsigned row_at;
  logic [1:0]  good_frames;

  // Tile commands of the current body byte, and all commands still owed
  out_beat_t   step_tiles[$];
  out_beat_t   expected_tiles[$];
  out_beat_t   want;
  int unsigned mismatches;

  function automatic int unsigned cols_in_use();
    int unsigned c;
    c = cfg_across;
    if (c < 1) c = 1;
    if (c > MAX_TILES_X) c = MAX_TILES_X;
    return c;
  endfunction

  function automatic int unsigned rows_in_use();
    int unsigned r;
    r = cfg_down;
    if (r < 1) r = 1;
    if (r > MAX_TILES_Y) r = MAX_TILES_Y;
    return r;
  endfunction

  function automatic string tile_text(out_beat_t t);
    return $sformatf("col %0d row %0d hist %0d idx %h st %0d done %0d last %0d",
                     t.tile_column, t.tile_row, t.from_history, t.codebook_index,
                     t.status, t.frame_complete, t.run_last);
  endfunction

  // Queue one tile command at the current position; a byte makes at most 32
  function automatic void add_tile(logic hist, logic [15:0] idx, logic [1:0] st);
    out_beat_t t;
    if (step_tiles.size() >= MaxResults) return;
    t.tile_column    = 6'(col_at);
    t.tile_row       = 5'(row_at);
    t.from_history   = hist;
    t.codebook_index = hist ? 16'h0000 : idx;
    t.status         = st;
    t.frame_complete = 1'b0;
    t.run_last       = 1'b0;
    step_tiles.push_back(t);
  endfunction

  // Move past the tile just made; returns 1 once the frame is done
  function automatic bit step_past_tile();
    row_at++;
    if (row_at >= rows_in_use()) begin
      row_at = 0;
      if (col_at + 1 >= cols_in_use()) return 1'b1;
      col_at++;
      walk_phase = PhMask;
      mask_count = 0;
      mask_bits  = '0;
    end
    return 1'b0;
  endfunction

  function automatic void close_good_frame();
    if (step_tiles.size() > 0) step_tiles[step_tiles.size() - 1].frame_complete = 1'b1;
    if (good_frames < FramesForHistory) good_frames++;
    walk_phase = PhIdle;
  endfunction

  // History copies for set mask bits, until a clear bit, a column end or an error
  function automatic void play_skips();
    while (walk_phase == PhIndex && mask_bits[31]) begin
      if (good_frames < FramesForHistory) begin
        add_tile(1'b1, 16'h0000, StNoHistory);
        walk_phase = PhIdle;
        return;
      end
      add_tile(1'b1, 16'h0000, StOk);
      mask_bits = mask_bits << 1;
      if (step_past_tile()) begin
        close_good_frame();
        return;
      end
    end
  endfunction

  // Expected tile commands for one accepted body byte
  function automatic void predict_byte(in_beat_t b);
    logic [15:0] idx;
    step_tiles.delete();
    if (b.first_byte) begin
      walk_phase = PhMask;
      mask_bits  = '0;
      mask_count = 0;
      index_hi   = '0;
      col_at     = 0;
      row_at     = 0;
    end
    case (walk_phase)
      PhMask: begin
        mask_bits = {mask_bits[23:0], b.body_byte};
        mask_count++;
        if (mask_count >= MaskBytes) begin
          mask_count = 0;
          walk_phase = PhIndex;
          play_skips();
        end
      end
      PhIndex: begin
        if (mask_count == 0) begin
          index_hi   = b.body_byte;
          mask_count = 1;
        end else begin
          idx        = {index_hi, b.body_byte};
          mask_count = 0;
          mask_bits  = mask_bits << 1;
          if (idx >= cfg_entries) begin
            add_tile(1'b0, idx, StBadIndex);
            walk_phase = PhIdle;
          end else begin
            add_tile(1'b0, idx, StOk);
            if (step_past_tile()) close_good_frame();
            else play_skips();
          end
        end
      end
      default: ;
    endcase
    // body ends with the frame still open
    if (b.last_byte && walk_phase != PhIdle) begin
      if (step_tiles.size() < MaxResults) add_tile(1'b0, 16'h0000, StTruncated);
      else step_tiles[MaxResults - 1].status = StTruncated;
      walk_phase = PhIdle;
    end
    if (step_tiles.size() > 0) step_tiles[step_tiles.size() - 1].run_last = 1'b1;
    foreach (step_tiles[k]) expected_tiles.push_back(step_tiles[k]);
  endfunction

  // Sample both channels and the register port at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_across  = ResetTilesAcross;
      cfg_down    = ResetTilesDown;
      cfg_entries = ResetCodebookEntries;
      walk_phase  = PhIdle;
      mask_bits   = '0;
      mask_count  = 0;
      index_hi    = '0;
      col_at      = 0;
      row_at      = 0;
      good_frames = '0;
      expected_tiles.delete();
      mismatches  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgTilesAcross:     cfg_across  = cfg_wdata_i[6:0];
          CfgTilesDown:       cfg_down    = cfg_wdata_i[5:0];
          CfgCodebookEntries: cfg_entries = cfg_wdata_i;
          default: ;
        endcase
      end
      // result beat against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (expected_tiles.size() == 0) begin
          if (mismatches < MaxReports) begin
            $display("tile check: unexpected command %s", tile_text(out_data_i));
          end
          mismatches++;
        end else begin
          want = expected_tiles.pop_front();
          if (out_data_i.tile_column !== want.tile_column ||
              out_data_i.tile_row !== want.tile_row ||
              out_data_i.from_history !== want.from_history ||
              out_data_i.codebook_index !== want.codebook_index ||
              out_data_i.status !== want.status ||
              out_data_i.frame_complete !== want.frame_complete ||
              out_data_i.run_last !== want.run_last) begin
            if (mismatches < MaxReports) begin
              $display("tile check: expected %s", tile_text(want));
              $display("tile check:      got %s", tile_text(out_data_i));
            end
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_byte(in_data_i);
    end
    tiles_pending_o  <= expected_tiles.size();
    mismatch_count_o <= mismatches;
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Bench top for the tile skip-mask decoder: clock, reset, stimulus and verdict.
module testbench;
  import vtsm_pkg::*;

  localparam int RandomBytes  = 170;
  localparam int PhaseBytes   = 30;
  localparam int CycleLimit   = 500000;
  localparam int SettleCycles = 8;
  localparam int LongHold     = 150;
  localparam int FrameCap     = 32;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  in_beat_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_beat_t           out_data_o;

  int unsigned tiles_pending;
  int unsigned mismatch_count;
  int unsigned cycle_count = 0;

  // Idle knobs for both sides, and the one long receiver hold-off
  int unsigned tx_gap_max;
  int unsigned rx_gap_max;
  int unsigned rx_hold_cycles;

  // Register values as last written, used to shape frames
  int unsigned cur_across;
  int unsigned cur_down;
  int unsigned cur_entries;

  int unsigned random_bytes;
  int unsigned phase_no;
  int unsigned phase_start;

  vq_tile_skip_mask_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  tile_command_checker tile_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .tiles_pending_o  (tiles_pending),
    .mismatch_count_o (mismatch_count)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stall before each beat, one long hold-off on request
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, rx_gap_max);
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic in_beat_t beat_of(logic [7:0] b, logic first, logic last);
    in_beat_t t;
    t.body_byte  = b;
    t.first_byte = first;
    t.last_byte  = last;
    return t;
  endfunction

  // Offer one body byte after a random gap and hold it until taken
  task automatic send_beat(in_beat_t beat);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Wait until every expected command is out, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (tiles_pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_config(int unsigned across, int unsigned down, int unsigned entries);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgTilesAcross;
    cfg_wdata_i <= CfgDataW'(across);
    @(posedge clk_i);
    cfg_index_i <= CfgTilesDown;
    cfg_wdata_i <= CfgDataW'(down);
    @(posedge clk_i);
    cfg_index_i <= CfgCodebookEntries;
    cfg_wdata_i <= CfgDataW'(entries);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_across  = across;
    cur_down    = down;
    cur_entries = entries;
  endtask

  // One frame body: mostly well formed, some cut short, some plain noise
  task automatic play_frame();
    in_beat_t    beats[$];
    logic [31:0] mask;
    logic [15:0] idx;
    int unsigned cols, rows, kind, cut, len;
    int          c, r, k;
    cols = (cur_across < 1) ? 1 : ((cur_across > 64) ? 64 : cur_across);
    rows = (cur_down < 1) ? 1 : ((cur_down > 32) ? 32 : cur_down);
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      len = $urandom_range(1, 8);
      repeat (len) begin
        beats.push_back(beat_of(8'($urandom), $urandom_range(0, 3) == 0,
                                $urandom_range(0, 3) == 0));
      end
    end else begin
      for (c = 0; c < cols && beats.size() < FrameCap; c++) begin
        case ($urandom_range(0, 5))
          0:       mask = '0;
          1:       mask = '1;
          2:       mask = $urandom;
          default: mask = $urandom & $urandom;
        endcase
        for (k = 3; k >= 0; k--) beats.push_back(beat_of(mask[8*k +: 8], 1'b0, 1'b0));
        for (r = 0; r < rows && beats.size() < FrameCap; r++) begin
          if (!mask[31-r]) begin
            if (cur_entries > 0 && $urandom_range(0, 7) != 0) begin
              idx = 16'($urandom_range(0, cur_entries - 1));
            end else begin
              idx = 16'($urandom);
            end
            beats.push_back(beat_of(idx[15:8], 1'b0, 1'b0));
            beats.push_back(beat_of(idx[7:0], 1'b0, 1'b0));
          end
        end
      end
      beats[0].first_byte = 1'b1;
      // cut short, or leave open so the next first byte drops it
      if (kind < 7) begin
        cut = $urandom_range(1, beats.size());
        while (beats.size() > cut) void'(beats.pop_back());
      end
      if (kind != 7) beats[beats.size() - 1].last_byte = 1'b1;
    end
    // trailing bytes past the body
    if ($urandom_range(0, 4) == 0) begin
      beats.push_back(beat_of(8'($urandom), 1'b0, 1'($urandom_range(0, 1))));
    end
    foreach (beats[k]) send_beat(beats[k]);
    random_bytes += beats.size();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CfgTilesAcross;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    tx_gap_max     = 6;
    rx_gap_max     = 6;
    rx_hold_cycles = 0;
    random_bytes   = 0;
    phase_no       = 0;
    phase_start    = 0;
    cur_across     = ResetTilesAcross;
    cur_down       = ResetTilesDown;
    cur_entries    = ResetCodebookEntries;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One tile per frame, 16 codebook entries
    write_config(1, 1, 16);
    // stray byte before any frame
    send_beat(beat_of(8'h55, 1'b0, 1'b0));
    // skip bit with no decoded frames yet
    send_beat(beat_of(8'h80, 1'b1, 1'b0));
    repeat (3) send_beat(beat_of(8'h00, 1'b0, 1'b0));
    // index out of range, largest index
    send_beat(beat_of(8'h00, 1'b1, 1'b0));
    repeat (3) send_beat(beat_of(8'h00, 1'b0, 1'b0));
    send_beat(beat_of(8'hFF, 1'b0, 1'b0));
    send_beat(beat_of(8'hFF, 1'b0, 1'b0));
    // good frame, highest legal index
    send_beat(beat_of(8'h00, 1'b1, 1'b0));
    repeat (4) send_beat(beat_of(8'h00, 1'b0, 1'b0));
    send_beat(beat_of(8'h0F, 1'b0, 1'b0));
    // frame dropped mid-body by a new first byte, which then completes
    send_beat(beat_of(8'hAB, 1'b1, 1'b0));
    send_beat(beat_of(8'hCD, 1'b0, 1'b0));
    send_beat(beat_of(8'h00, 1'b1, 1'b0));
    repeat (4) send_beat(beat_of(8'h00, 1'b0, 1'b0));
    send_beat(beat_of(8'h00, 1'b0, 1'b1));
    // byte after a completed frame
    send_beat(beat_of(8'hAA, 1'b0, 1'b0));
    settle();

    // Full 32-tile skip run on a body that ends there, then a one-byte body
    write_config(2, 32, 65535);
    send_beat(beat_of(8'hFF, 1'b1, 1'b0));
    repeat (2) send_beat(beat_of(8'hFF, 1'b0, 1'b0));
    send_beat(beat_of(8'hFF, 1'b0, 1'b1));
    send_beat(beat_of(8'h00, 1'b1, 1'b1));

    // Random phases, each with its own register setting and idle pattern
    while (random_bytes < RandomBytes) begin
      settle();
      case (phase_no)
        0: write_config(64, 32, 65535);
        1: write_config(1, 1, 1);
        2: write_config(0, 0, 0);
        3: write_config(127, 63, $urandom_range(0, 65535));
        4: write_config(2, 32, $urandom_range(1, 65535));
        default: begin
          write_config($urandom_range(1, 4), $urandom_range(1, 8),
                       $urandom_range(0, 1) ? $urandom_range(1, 300)
                                            : $urandom_range(0, 65535));
        end
      endcase
      tx_gap_max = $urandom_range(0, 1) ? 6 : 0;
      rx_gap_max = $urandom_range(0, 1) ? 6 : 0;
      // long receiver hold-off while bytes keep coming
      if (phase_no == 0) begin
        tx_gap_max     = 0;
        rx_hold_cycles = LongHold;
      end
      phase_start = random_bytes;
      while (random_bytes - phase_start < PhaseBytes) play_frame();
      phase_no++;
    end

    settle();
    if (mismatch_count == 0 && tiles_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* vq_tile_skip_mask_decoder.f */
+incdir+rtl
rtl/vtsm_pkg.sv
rtl/vtsm_ctrl.sv
rtl/vtsm_datapath.sv
rtl/vq_tile_skip_mask_decoder.sv
rtl/vtsm_checker.sv
bench/tile_command_checker.sv
bench/testbench.sv
